// File: rtl/core/ascii_rtcm_frame_parser_top_defines.svh
// Assertion macros shared by the frame parser RTL.
// They need nothing else; files that check their logic include this header.
`ifndef ASCII_RTCM_FRAME_PARSER_TOP_DEFINES_SVH
`define ASCII_RTCM_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define AFP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("frame parser check failed");
// Checked on every clock edge, reset included.
`define AFP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("frame parser reset check failed");
`else
`define AFP_ASSERT(lbl, prop)
`define AFP_ASSERT_RST(lbl, prop)
`endif

`endif

// File: rtl/core/afp_pkg.sv
// Constants, result type and CRC-24Q byte update for the frame parser.
// It depends on nothing; the parser step and the top level import it.
`default_nettype none
package afp_pkg;

    localparam int BUFFER_BYTES = 2048;
    localparam int MAX_FIELDS   = 64;

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam int BC_W  = $clog2(MAX_FIELDS + 1);
    localparam int CMP_W = ((CNT_W > 11) ? CNT_W : 11) + 1;

    localparam int POS_W   = 11;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 48;

    localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
    localparam logic [11:0] SUBTYPE_TYPE  = 12'd4058;
    localparam logic [24:0] CRC24Q_POLY   = 25'h1864CFB;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_TEXT = 2'd1;
    localparam logic [1:0] ST_RTCM = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic               taken;
        logic [POS_W-1:0]   position;
        logic               mark;
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   length;
        logic [11:0]        mtype;
        logic [3:0]         msub;
        logic               crc_err;
    } afp_result_t;

    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC24Q_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/afp_step.sv
// Parser state and the per-byte update that produces one result.
// It depends on afp_pkg for constants, the result type and the CRC update.
`default_nettype none
module afp_step (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step_en,
    input  wire logic [7:0]   data_byte,
    output afp_pkg::afp_result_t result
);
    import afp_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rtcm_reg, rtcm_next;
    logic [31:0]      recent_reg, recent_next;
    logic [9:0]       plen_reg, plen_next;
    logic [11:0]      type_reg, type_next;
    logic [3:0]       sub_reg, sub_next;
    logic [23:0]      crc_reg, crc_next;
    logic [BC_W-1:0]  bc_reg, bc_next;

    logic [CNT_W-1:0] cnt_chk;
    logic [CNT_W-1:0] cnt_inc;
    logic             start;
    logic             opens;
    logic [31:0]      recent_e;
    logic [9:0]       plen_e;
    logic [11:0]      type_e;
    logic [3:0]       sub_e;
    logic [23:0]      crc_e;
    logic [23:0]      crc_upd;
    logic [BC_W-1:0]  bc_e;

    assign crc_upd = crc24q_byte(crc_e, data_byte);

    always_comb begin
        cnt_chk = (cnt_reg >= CNT_W'(BUFFER_BYTES - 1)) ? '0 : cnt_reg;
        if (cnt_chk == CNT_W'(1) && !rtcm_reg && data_byte != CH_A) begin
            cnt_chk = '0;
        end
        if (cnt_chk == CNT_W'(2) && !rtcm_reg && data_byte != CH_P) begin
            cnt_chk = '0;
        end
        start = (cnt_chk == '0);
        opens = (data_byte == CH_HASH) || (data_byte == RTCM_PREAMBLE);

        rtcm_next   = start ? (data_byte == RTCM_PREAMBLE) : rtcm_reg;
        recent_e    = start ? '0 : recent_reg;
        plen_e      = start ? '0 : plen_reg;
        type_e      = start ? '0 : type_reg;
        sub_e       = start ? '0 : sub_reg;
        crc_e       = start ? '0 : crc_reg;
        bc_e        = start ? '0 : bc_reg;
        cnt_inc     = cnt_chk + CNT_W'(1);

        cnt_next    = cnt_chk;
        recent_next = recent_reg;
        plen_next   = plen_reg;
        type_next   = type_reg;
        sub_next    = sub_reg;
        crc_next    = crc_reg;
        bc_next     = bc_reg;
        result      = '0;

        if (!start || opens) begin
            recent_next = {recent_e[23:0], data_byte};
            cnt_next    = cnt_inc;
            plen_next   = plen_e;
            type_next   = type_e;
            sub_next    = sub_e;
            crc_next    = crc_e;
            bc_next     = bc_e;

            result.taken    = 1'b1;
            result.position = POS_W'(cnt_chk);

            if (cnt_chk < CNT_W'(3)) begin
                if (rtcm_next) begin
                    crc_next = crc_upd;
                    if (cnt_chk == CNT_W'(1)) begin
                        plen_next = {data_byte[1:0], 8'h00};
                    end else if (cnt_chk == CNT_W'(2)) begin
                        plen_next = {plen_e[9:8], data_byte};
                    end
                end
            end else if (!rtcm_next) begin
                if (data_byte == CH_COMMA && bc_e < BC_W'(MAX_FIELDS)) begin
                    bc_next     = bc_e + BC_W'(1);
                    result.mark = 1'b1;
                end
                if ((data_byte inside {CH_CR, CH_LF}) && recent_next[31:24] == CH_STAR) begin
                    if (bc_next < BC_W'(MAX_FIELDS)) begin
                        bc_next = bc_next + BC_W'(1);
                    end
                    result.status = ST_TEXT;
                    result.length = POS_W'(cnt_inc);
                    cnt_next      = '0;
                end
            end else begin
                if (CMP_W'(cnt_chk) < CMP_W'(plen_e) + CMP_W'(3)) begin
                    crc_next = crc_upd;
                end
                if (cnt_chk == CNT_W'(3)) begin
                    type_next = {data_byte, 4'h0};
                end else if (cnt_chk == CNT_W'(4)) begin
                    type_next = {type_e[11:4], data_byte[7:4]};
                    sub_next  = data_byte[3:0];
                end
                if (CMP_W'(cnt_inc) >= CMP_W'(plen_e) + CMP_W'(6)) begin
                    result.status = ST_RTCM;
                    result.length = POS_W'(cnt_inc);
                    result.mtype  = type_next;
                    if (crc_next != recent_next[23:0]) begin
                        result.crc_err = 1'b1;
                    end else if (type_next == SUBTYPE_TYPE) begin
                        result.msub = sub_next;
                    end
                    cnt_next = '0;
                end
            end
            result.count = COUNT_W'(bc_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rtcm_reg   <= 1'b0;
            recent_reg <= '0;
            plen_reg   <= '0;
            type_reg   <= '0;
            sub_reg    <= '0;
            crc_reg    <= '0;
            bc_reg     <= '0;
        end else if (step_en) begin
            cnt_reg    <= cnt_next;
            rtcm_reg   <= rtcm_next;
            recent_reg <= recent_next;
            plen_reg   <= plen_next;
            type_reg   <= type_next;
            sub_reg    <= sub_next;
            crc_reg    <= crc_next;
            bc_reg     <= bc_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ascii_rtcm_frame_parser_top.sv
// Frame parser top level: input register, parser step, result register.
// An input byte is held in the input register, and its result is registered in the result register for the m_ side.
// Throughput is one byte per cycle unless m_tready low stalls the output.
// Every input byte gives exactly one result transfer; m_tready low stalls both sides.
// aresetn is synchronous and active low; it empties both registers and clears the parser.
`default_nettype none
`include "ascii_rtcm_frame_parser_top_defines.svh"
module ascii_rtcm_frame_parser_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,  // [7:0] data_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [0] byte_taken, [11:1] byte_position, [12] field_mark, [19:13] field_count,
    // [30:20] frame_length, [42:31] message_type, [46:43] message_subtype, [47] crc_error
    output logic [afp_pkg::DATA_W-1:0]      m_tdata,
    output logic [1:0]                      m_tuser   // [1:0] frame_status
);
    import afp_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              advance;
    logic              step_en;
    afp_result_t       step_result;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    afp_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (step_en) begin
            out_status_reg <= step_result.status;
            out_data_reg   <= {step_result.crc_err, step_result.msub, step_result.mtype,
                               step_result.length, step_result.count, step_result.mark,
                               step_result.position, step_result.taken};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `AFP_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid && s_tready)
    `AFP_ASSERT(a_step_fills_output, step_en |=> m_tvalid)
    `AFP_ASSERT(a_untaken_is_zero, m_tvalid && !m_tdata[0] |-> m_tdata == '0 && m_tuser == ST_NONE)
    `AFP_ASSERT(a_crc_err_only_rtcm, m_tvalid && m_tdata[47] |-> m_tuser == ST_RTCM)
    `AFP_ASSERT(a_done_has_length, m_tvalid && m_tuser != ST_NONE |-> m_tdata[30:20] != '0)

endmodule
`default_nettype wire
